// ===== hdl/chash_pkg.sv =====
// shared types and codes for the coalesced hash table
package chash_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 3;
  localparam int IDX_W   = 8;

  localparam int HASH_MUL = 228;
  localparam int HASH_ADD = 1337;
  localparam int HOME_PCT = 86;
  localparam int HOME_DIV = 100;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] ST_HIT       = 3'd0;
  localparam logic [STAT_W-1:0] ST_MISS      = 3'd1;
  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd2;
  localparam logic [STAT_W-1:0] ST_OVERWRITE = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd5;

endpackage

// ===== hdl/chash_ifs.sv =====
// request and result channel interfaces
interface chash_in_if import chash_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;
  modport source (output valid, cmd, key, value, input ready);
  modport sink (input valid, cmd, key, value, output ready);
endinterface

interface chash_out_if import chash_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [VALUE_W-1:0] found_value;
  logic [IDX_W-1:0]   slot_index;
  modport source (output valid, status, found_value, slot_index, input ready);
  modport sink (input valid, status, found_value, slot_index, output ready);
endinterface

// ===== hdl/chash_ram.sv =====
// generic single-write, single-read ram with registered read data
module chash_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/coalesced_hash_table_top.sv =====
// coalesced hash table: lookup, insert and remove over one entry ram
//
//  channel | dir | handshake        | payload
//  in_ch   | in  | valid / ready    | cmd, key, value
//  out_ch  | out | valid / ready    | status, found_value, slot_index
//
// one request at a time; a request walks its chain from the home slot with
// one ram read per chain slot visited, plus a downward free slot scan over
// groups of up to 16 slots and one link write on a chained insert, or one
// entry copy when a removed chain head pulls in its successor
// slot-used bits are flip-flops cleared by the synchronous reset, no sweep
// the result waits in the output register; the next request is taken as
// soon as the result is loaded there
module coalesced_hash_table_top import chash_pkg::*; #(
  parameter int TABLE_SLOTS = 256,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  chash_in_if.sink    in_ch,
  chash_out_if.source out_ch
);

  function automatic int home_span(int n);
    int m;
    int p;
    int i;
    m = n * HOME_PCT / HOME_DIV;
    p = 1;
    for (i = 0; i < 17; i++) begin
      if (p * 2 <= m) p = p * 2;
    end
    if (m < 2) p = 2;
    if (p > n) p = n;
    return p;
  endfunction

  localparam int IW     = $clog2(TABLE_SLOTS);
  localparam int LW     = IW + 1;
  localparam int EW     = KEY_BITS + VALUE_BITS + LW;
  localparam int HW     = KEY_BITS + 8;
  localparam int HOME_P = home_span(TABLE_SLOTS);
  localparam int GW     = (TABLE_SLOTS < 16) ? TABLE_SLOTS : 16;
  localparam int GWB    = $clog2(GW);
  localparam int NG     = TABLE_SLOTS / GW;
  localparam int GBW    = (NG > 1) ? $clog2(NG) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_WALK, S_HEADCP, S_SCAN, S_LINK, S_FIN
  } state_t;

  state_t                  state_r, state_nxt;
  logic [1:0]              cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0]     key_r, key_nxt;
  logic [VALUE_BITS-1:0]   val_r, val_nxt;
  logic [IW-1:0]           cur_r, cur_nxt;
  logic [IW-1:0]           prev_r, prev_nxt;
  logic                    has_prev_r, has_prev_nxt;
  logic [EW-1:0]           prev_ent_r, prev_ent_nxt;
  logic [EW-1:0]           cur_ent_r, cur_ent_nxt;
  logic [IW-1:0]           cnt_r, cnt_nxt;
  logic [GBW-1:0]          grp_r, grp_nxt;
  logic [IW-1:0]           nxt_r, nxt_nxt;
  logic [STAT_W-1:0]       res_status_r, res_status_nxt;
  logic [VALUE_BITS-1:0]   res_fv_r, res_fv_nxt;
  logic [IW-1:0]           res_idx_r, res_idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]       out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]      out_fv_r, out_fv_nxt;
  logic [IDX_W-1:0]        out_idx_r, out_idx_nxt;
  logic [TABLE_SLOTS-1:0]  used_r, used_nxt;

  logic                    ram_we;
  logic [IW-1:0]           ram_waddr;
  logic [EW-1:0]           ram_wdata;
  logic [IW-1:0]           ram_raddr;
  logic [EW-1:0]           ram_rdata;

  logic [KEY_BITS-1:0]     key_in;
  logic [VALUE_BITS-1:0]   val_in;
  logic [HW-1:0]           hsum;
  logic [IW-1:0]           home;
  logic                    in_fire;

  logic [KEY_BITS-1:0]     rd_key;
  logic [VALUE_BITS-1:0]   rd_data;
  logic [LW-1:0]           rd_link;
  logic [IW-1:0]           rd_tgt;
  logic                    rd_next;
  logic                    rd_match;
  logic                    walk_limit;

  logic [GW-1:0]           grp_free;
  logic [GWB-1:0]          grp_hi;
  logic [IW-1:0]           free_slot;

  assign key_in  = KEY_BITS'(in_ch.key);
  assign val_in  = VALUE_BITS'(in_ch.value);
  assign hsum    = HW'(key_in) * HW'(HASH_MUL) + HW'(HASH_ADD);
  assign home    = IW'(hsum & HW'(HOME_P - 1));
  assign in_fire = in_ch.valid && (state_r == S_IDLE);

  assign rd_key     = ram_rdata[EW-1 -: KEY_BITS];
  assign rd_data    = ram_rdata[LW +: VALUE_BITS];
  assign rd_link    = ram_rdata[LW-1:0];
  assign rd_tgt     = rd_link[IW-1:0];
  assign rd_next    = rd_link[IW] && used_r[rd_tgt];
  assign rd_match   = (rd_key == key_r);
  assign walk_limit = (cnt_r == IW'(TABLE_SLOTS - 1));

  // highest free slot of the current group of the downward scan
  assign grp_free = ~used_r[IW'(grp_r) * IW'(GW) +: GW];
  always_comb begin
    grp_hi = '0;
    for (int i = 0; i < GW; i++) begin
      if (grp_free[i]) grp_hi = GWB'(i);
    end
  end
  assign free_slot = IW'(grp_r) * IW'(GW) + IW'(grp_hi);

  assign ram_raddr = (state_r == S_IDLE) ? home : rd_tgt;

  chash_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    has_prev_nxt   = has_prev_r;
    prev_ent_nxt   = prev_ent_r;
    cur_ent_nxt    = cur_ent_r;
    cnt_nxt        = cnt_r;
    grp_nxt        = grp_r;
    nxt_nxt        = nxt_r;
    res_status_nxt = res_status_r;
    res_fv_nxt     = res_fv_r;
    res_idx_nxt    = res_idx_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_fv_nxt     = out_fv_r;
    out_idx_nxt    = out_idx_r;
    used_nxt       = used_r;
    ram_we         = 1'b0;
    ram_waddr      = cur_r;
    ram_wdata      = '0;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt        = in_ch.cmd;
          key_nxt        = key_in;
          val_nxt        = val_in;
          cur_nxt        = home;
          has_prev_nxt   = 1'b0;
          cnt_nxt        = '0;
          res_status_nxt = ST_MISS;
          res_fv_nxt     = '0;
          res_idx_nxt    = '0;
          state_nxt      = S_FIN;
          if (in_ch.cmd == CMD_INSERT) begin
            if (!used_r[home]) begin
              ram_we         = 1'b1;
              ram_waddr      = home;
              ram_wdata      = {key_in, val_in, LW'(0)};
              used_nxt[home] = 1'b1;
              res_status_nxt = ST_INSERTED;
              res_idx_nxt    = home;
            end else begin
              state_nxt = S_WALK;
            end
          end else if (in_ch.cmd == CMD_LOOKUP || in_ch.cmd == CMD_REMOVE) begin
            if (used_r[home]) state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        cur_ent_nxt = ram_rdata;
        if (rd_match) begin
          state_nxt   = S_FIN;
          res_idx_nxt = cur_r;
          if (cmd_r == CMD_LOOKUP) begin
            res_status_nxt = ST_HIT;
            res_fv_nxt     = rd_data;
          end else if (cmd_r == CMD_INSERT) begin
            ram_we         = 1'b1;
            ram_wdata      = {rd_key, val_r, rd_link};
            res_status_nxt = ST_OVERWRITE;
          end else begin
            res_status_nxt = ST_REMOVED;
            if (has_prev_r) begin
              // unlink: predecessor inherits our link
              ram_we          = 1'b1;
              ram_waddr       = prev_r;
              ram_wdata       = {prev_ent_r[EW-1:LW], rd_link};
              used_nxt[cur_r] = 1'b0;
            end else if (rd_next) begin
              // chain head: pull the successor in
              nxt_nxt   = rd_tgt;
              state_nxt = S_HEADCP;
            end else begin
              used_nxt[cur_r] = 1'b0;
            end
          end
        end else if (rd_next && !walk_limit) begin
          prev_nxt     = cur_r;
          prev_ent_nxt = ram_rdata;
          has_prev_nxt = 1'b1;
          cur_nxt      = rd_tgt;
          cnt_nxt      = cnt_r + IW'(1);
        end else if (cmd_r == CMD_INSERT) begin
          grp_nxt   = GBW'(NG - 1);
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_HEADCP: begin
        ram_we          = 1'b1;
        ram_wdata       = ram_rdata;
        used_nxt[nxt_r] = 1'b0;
        state_nxt       = S_FIN;
      end
      S_SCAN: begin
        if (|grp_free) begin
          ram_we              = 1'b1;
          ram_waddr           = free_slot;
          ram_wdata           = {key_r, val_r, LW'(0)};
          used_nxt[free_slot] = 1'b1;
          nxt_nxt             = free_slot;
          res_status_nxt      = ST_INSERTED;
          res_idx_nxt         = free_slot;
          state_nxt           = S_LINK;
        end else if (grp_r == '0) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_FIN;
        end else begin
          grp_nxt = grp_r - GBW'(1);
        end
      end
      S_LINK: begin
        ram_we    = 1'b1;
        ram_wdata = {cur_ent_r[EW-1:LW], 1'b1, nxt_r};
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_fv_nxt     = VALUE_W'(res_fv_r);
          out_idx_nxt    = IDX_W'(res_idx_r);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      has_prev_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      used_r      <= used_nxt;
      has_prev_r  <= has_prev_nxt;
    end
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    prev_ent_r   <= prev_ent_nxt;
    cur_ent_r    <= cur_ent_nxt;
    cnt_r        <= cnt_nxt;
    grp_r        <= grp_nxt;
    nxt_r        <= nxt_nxt;
    res_status_r <= res_status_nxt;
    res_fv_r     <= res_fv_nxt;
    res_idx_r    <= res_idx_nxt;
    out_status_r <= out_status_nxt;
    out_fv_r     <= out_fv_nxt;
    out_idx_r    <= out_idx_nxt;
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.found_value  = out_fv_r;
  assign out_ch.slot_index   = out_idx_r;

endmodule

// ===== hdl/chash_chk.sv =====
// port-level checks for the coalesced hash table, bound to the top level
module chash_chk import chash_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [STAT_W-1:0]  out_status,
  input logic [VALUE_W-1:0] out_found_value,
  input logic [IDX_W-1:0]   out_slot_index
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_REMOVED)
    else $error("status code out of range");

  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_MISS || out_status == ST_FULL)
      |-> out_slot_index == '0)
    else $error("miss or full with nonzero slot");

  a_value_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_HIT |-> out_found_value == '0)
    else $error("found value on a non-hit");

  // a result does not rise in the cycle after its request is accepted
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early");

endmodule

bind coalesced_hash_table_top chash_chk u_chash_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_found_value (out_ch.found_value),
  .out_slot_index  (out_ch.slot_index)
);

// ===== tb/tb_coalesced_hash_table_top.sv =====
// testbench for the coalesced hash table: predictor, driver and monitor
module tb_coalesced_hash_table_top;
  import chash_pkg::*;

  localparam int SLOTS = 256;
  localparam int HOMES = 128;
  localparam int CYCLE_LIMIT = 5000000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [VALUE_W-1:0] found_value;
    logic [IDX_W-1:0]   slot_index;
  } answer_t;

  logic clk;
  logic rst_n;

  chash_in_if  in_ch ();
  chash_out_if out_ch ();

  coalesced_hash_table_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predicted table contents
  bit                 tbl_used [SLOTS];
  logic [KEY_W-1:0]   tbl_key  [SLOTS];
  logic [VALUE_W-1:0] tbl_data [SLOTS];
  bit                 tbl_lnk_ok [SLOTS];
  int unsigned        tbl_lnk  [SLOTS];

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  logic [KEY_W-1:0] key_pool[$];

  int mismatches;
  int cycles;
  int drv_wait;
  int mon_wait;
  bit stim_done;

  function automatic int unsigned home_slot(logic [KEY_W-1:0] k);
    logic [63:0] h;
    h = 64'(HASH_MUL) * 64'(k) + 64'(HASH_ADD);
    return int'(h & 64'(HOMES - 1));
  endfunction

  function automatic bit follow(int unsigned s, output int unsigned nxt);
    nxt = tbl_lnk[s];
    return tbl_lnk_ok[s] && nxt < SLOTS && tbl_used[nxt];
  endfunction

  function automatic bit chain_search(logic [KEY_W-1:0] k, output int unsigned cur,
                                      output int unsigned prv, output bit has_prv);
    int unsigned c, n;
    has_prv = 0;
    prv = 0;
    c = home_slot(k);
    cur = c;
    if (!tbl_used[c]) return 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_key[c] == k) begin
        cur = c;
        return 1;
      end
      if (!follow(c, n)) break;
      prv = c;
      has_prv = 1;
      c = n;
    end
    cur = c;
    return 0;
  endfunction

  function automatic void release_slot(int unsigned s);
    tbl_used[s] = 0;
    tbl_lnk_ok[s] = 0;
    tbl_lnk[s] = 0;
  endfunction

  function automatic answer_t apply_request(request_t r);
    answer_t a;
    int unsigned cur, prv, nxt, h, f;
    bit has_prv, got;
    a = '{status: ST_MISS, found_value: '0, slot_index: '0};
    if (r.cmd == CMD_LOOKUP) begin
      if (chain_search(r.key, cur, prv, has_prv)) begin
        a.status = ST_HIT;
        a.found_value = tbl_data[cur];
        a.slot_index = IDX_W'(cur);
      end
    end else if (r.cmd == CMD_INSERT) begin
      h = home_slot(r.key);
      if (!tbl_used[h]) begin
        tbl_used[h] = 1;
        tbl_key[h] = r.key;
        tbl_data[h] = r.value;
        tbl_lnk_ok[h] = 0;
        tbl_lnk[h] = 0;
        a.status = ST_INSERTED;
        a.slot_index = IDX_W'(h);
      end else if (chain_search(r.key, cur, prv, has_prv)) begin
        tbl_data[cur] = r.value;
        a.status = ST_OVERWRITE;
        a.slot_index = IDX_W'(cur);
      end else begin
        got = 0;
        f = 0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
          if (!tbl_used[s]) begin
            got = 1;
            f = s;
            break;
          end
        end
        if (!got) begin
          a.status = ST_FULL;
        end else begin
          tbl_used[f] = 1;
          tbl_key[f] = r.key;
          tbl_data[f] = r.value;
          tbl_lnk_ok[f] = 0;
          tbl_lnk[f] = 0;
          tbl_lnk_ok[cur] = 1;
          tbl_lnk[cur] = f;
          a.status = ST_INSERTED;
          a.slot_index = IDX_W'(f);
        end
      end
    end else if (r.cmd == CMD_REMOVE) begin
      if (chain_search(r.key, cur, prv, has_prv)) begin
        if (has_prv) begin
          tbl_lnk_ok[prv] = tbl_lnk_ok[cur];
          tbl_lnk[prv] = tbl_lnk[cur];
          release_slot(cur);
        end else if (follow(cur, nxt)) begin
          // chain head pulls in its successor
          tbl_key[cur] = tbl_key[nxt];
          tbl_data[cur] = tbl_data[nxt];
          tbl_lnk_ok[cur] = tbl_lnk_ok[nxt];
          tbl_lnk[cur] = tbl_lnk[nxt];
          release_slot(nxt);
        end else begin
          release_slot(cur);
        end
        a.status = ST_REMOVED;
        a.slot_index = IDX_W'(cur);
      end
    end
    return a;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return $urandom();
  endfunction

  function automatic void queue_request(logic [1:0] c, logic [KEY_W-1:0] k,
                                        logic [VALUE_W-1:0] v);
    pending_reqs.push_back('{cmd: c, key: k, value: v});
    if (key_pool.size() < 400) key_pool.push_back(k);
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // stimulus
  initial begin
    logic [1:0] c;
    int unsigned r;
    // directed: extremes, collisions, repair of a chain head, absent keys
    queue_request(CMD_LOOKUP, 32'h0, 32'h0);
    queue_request(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
    queue_request(CMD_INSERT, 32'h0, 32'hFFFF_FFFF);
    queue_request(CMD_INSERT, 32'h0, 32'h1234_5678);
    queue_request(CMD_INSERT, 32'h80, 32'hAAAA_5555);
    queue_request(CMD_INSERT, 32'h100, 32'h5555_AAAA);
    queue_request(CMD_INSERT, 32'hFFFF_FFFF, 32'h0);
    queue_request(CMD_LOOKUP, 32'h100, 32'h0);
    queue_request(CMD_REMOVE, 32'h0, 32'h0);
    queue_request(CMD_LOOKUP, 32'h80, 32'h0);
    queue_request(CMD_REMOVE, 32'h100, 32'h0);
    queue_request(CMD_LOOKUP, 32'h100, 32'h0);
    queue_request(CMD_UNUSED, 32'h80, 32'h0);
    queue_request(CMD_REMOVE, 32'h80, 32'h0);
    queue_request(CMD_REMOVE, 32'h80, 32'h0);
    queue_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    // fill the table to full, then drain part of it
    for (int i = 0; i < 270; i++) queue_request(CMD_INSERT, $urandom(), $urandom());
    for (int i = 0; i < 150; i++) queue_request(CMD_REMOVE, pick_key(), 32'h0);
    key_pool.delete();
    for (int i = 0; i < 1100; i++) begin
      r = $urandom_range(0, 99);
      c = r < 40 ? CMD_INSERT : r < 70 ? CMD_LOOKUP : r < 97 ? CMD_REMOVE : CMD_UNUSED;
      queue_request(c, pick_key(), $urandom());
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.cmd <= '0;
      in_ch.key <= '0;
      in_ch.value <= '0;
      drv_wait <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected_answers.push_back(apply_request('{in_ch.cmd, in_ch.key,
                                                                  in_ch.value}));
      if (drv_wait > 0) begin
        in_ch.valid <= 1'b0;
        drv_wait <= drv_wait - 1;
      end else if (pending_reqs.size() > 0) begin
        request_t q;
        q = pending_reqs.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.cmd <= q.cmd;
        in_ch.key <= q.key;
        in_ch.value <= q.value;
        drv_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
      end else begin
        in_ch.valid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      mon_wait <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        answer_t got, exp;
        got = '{out_ch.status, out_ch.found_value, out_ch.slot_index};
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          exp = expected_answers.pop_front();
          if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp, got);
          end
        end
        mon_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
        out_ch.ready <= 1'b0;
      end else if (mon_wait > 0) begin
        mon_wait <= mon_wait - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    mismatches = 0;
    cycles = 0;
    stim_done = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.key = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (!(stim_done && expected_answers.size() == 0) && cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
    end else begin
      repeat (300) @(posedge clk);
      if (mismatches == 0 && expected_answers.size() == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/chash_pkg.sv
hdl/chash_ifs.sv
hdl/chash_ram.sv
hdl/coalesced_hash_table_top.sv
hdl/chash_chk.sv
tb/tb_coalesced_hash_table_top.sv
